// ===== src/trba_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trba_pkg
// shared types and constants for the two-row box average block
// ----------------------------------------------------------------------------
package trba_pkg;

    localparam int ELEV_W    = 32;
    localparam int SUM_W     = ELEV_W + 2;
    localparam int FRAC_BITS = 8;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_AVERAGE_ENABLE = 1'b0,
        CFG_NULL_AS_ZERO   = 1'b1
    } cfg_idx_t;

    typedef struct packed {
        logic average_enable;
        logic null_as_zero;
    } cfg_t;

    // one column of the two rows as held for the compute step
    typedef struct packed {
        logic                     valid;
        logic signed [ELEV_W-1:0] upper_elev;
        logic signed [ELEV_W-1:0] lower_elev;
        logic                     upper_null;
        logic                     lower_null;
        logic                     row_start;
        logic                     row_end;
        logic signed [ELEV_W-1:0] prev_upper;
        logic signed [ELEV_W-1:0] prev_lower;
        logic                     prev_upper_null;
        logic                     prev_lower_null;
        logic                     have_prev;
    } work_t;

    typedef struct packed {
        logic signed [ELEV_W-1:0] out_elev;
        logic                     out_null;
        logic                     out_last;
    } result_t;

endpackage

// ===== src/trba_ifs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trba channel interfaces
// valid/ready channels for column samples and filtered results
// ----------------------------------------------------------------------------
interface trba_samples_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] upper_elev;
    logic signed [31:0] lower_elev;
    logic               upper_null;
    logic               lower_null;
    logic               row_start;
    logic               row_end;

    modport source (
        output valid, upper_elev, lower_elev, upper_null, lower_null, row_start, row_end,
        input  ready
    );
    modport sink (
        input  valid, upper_elev, lower_elev, upper_null, lower_null, row_start, row_end,
        output ready
    );
endinterface

interface trba_results_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] out_elev;
    logic               out_null;
    logic               out_last;

    modport source (
        output valid, out_elev, out_null, out_last,
        input  ready
    );
    modport sink (
        input  valid, out_elev, out_null, out_last,
        output ready
    );
endinterface

// ===== src/two_row_box_average.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_row_box_average
// 2x2 box filter over two raster rows streamed column by column
// ----------------------------------------------------------------------------
// Takes one column (upper and lower sample with null flags) per cycle while
// results are taken and, from the second column of a row on, gives one
// result per column: the floor mean of the 2x2 neighbourhood, or the previous
// upper sample in pass mode. A result passes through the input register, then
// the result register. A stalled result register holds the input side back
// only when the column in the input register produces a result. Configuration
// is written through the wr_en / wr_idx / wr_data port; the user must do so
// only while no item is in flight, as the block itself does not enforce it.
// ----------------------------------------------------------------------------
module two_row_box_average (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           wr_en,
    input  logic [trba_pkg::CFG_IDX_W-1:0] wr_idx,
    input  logic [trba_pkg::CFG_DAT_W-1:0] wr_data,
    trba_samples_if.sink                   samples,
    trba_results_if.source                 results
);
    import trba_pkg::*;

    cfg_t    cfg_reg;
    work_t   work;
    result_t result;
    logic    emit;
    logic    can_take;
    logic    advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.average_enable <= 1'b1;
            cfg_reg.null_as_zero   <= 1'b0;
        end
        else if (wr_en)
        begin
            case (cfg_idx_t'(wr_idx))
                CFG_AVERAGE_ENABLE: cfg_reg.average_enable <= wr_data[0];
                CFG_NULL_AS_ZERO:   cfg_reg.null_as_zero   <= wr_data[0];
                default:            cfg_reg                <= cfg_reg;
            endcase
        end
    end

    // column retires when it yields nothing or the result register is free
    assign advance = work.valid && (!emit || can_take);

    trba_col_hold u_col_hold (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (samples),
        .advance (advance),
        .work    (work)
    );

    trba_avg_core u_avg_core (
        .work   (work),
        .cfg    (cfg_reg),
        .emit   (emit),
        .result (result)
    );

    trba_out_reg u_out_reg (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (emit && advance),
        .result   (result),
        .can_take (can_take),
        .results  (results)
    );

endmodule

// ===== src/trba_col_hold.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trba_col_hold
// input register for the current column and storage of the previous column
// ----------------------------------------------------------------------------
module trba_col_hold (
    input  logic                clk,
    input  logic                rst_n,
    trba_samples_if.sink        samples,
    input  logic                advance,
    output trba_pkg::work_t     work
);
    import trba_pkg::*;

    logic                     valid_reg;
    logic signed [ELEV_W-1:0] upper_reg;
    logic signed [ELEV_W-1:0] lower_reg;
    logic                     upper_null_reg;
    logic                     lower_null_reg;
    logic                     row_start_reg;
    logic                     row_end_reg;
    logic signed [ELEV_W-1:0] prev_upper_reg;
    logic signed [ELEV_W-1:0] prev_lower_reg;
    logic                     prev_upper_null_reg;
    logic                     prev_lower_null_reg;
    logic                     have_prev_reg;
    logic                     load;

    assign samples.ready = !valid_reg || advance;
    assign load          = samples.valid && samples.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= 1'b0;
            have_prev_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                valid_reg <= 1'b0;
            end
            // a row end closes the row for the next item
            if (advance)
            begin
                have_prev_reg <= !row_end_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            upper_reg      <= samples.upper_elev;
            lower_reg      <= samples.lower_elev;
            upper_null_reg <= samples.upper_null;
            lower_null_reg <= samples.lower_null;
            row_start_reg  <= samples.row_start;
            row_end_reg    <= samples.row_end;
        end
        if (advance)
        begin
            prev_upper_reg      <= upper_reg;
            prev_lower_reg      <= lower_reg;
            prev_upper_null_reg <= upper_null_reg;
            prev_lower_null_reg <= lower_null_reg;
        end
    end

    assign work.valid           = valid_reg;
    assign work.upper_elev      = upper_reg;
    assign work.lower_elev      = lower_reg;
    assign work.upper_null      = upper_null_reg;
    assign work.lower_null      = lower_null_reg;
    assign work.row_start       = row_start_reg;
    assign work.row_end         = row_end_reg;
    assign work.prev_upper      = prev_upper_reg;
    assign work.prev_lower      = prev_lower_reg;
    assign work.prev_upper_null = prev_upper_null_reg;
    assign work.prev_lower_null = prev_lower_null_reg;
    assign work.have_prev       = have_prev_reg;

endmodule

// ===== src/trba_avg_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trba_avg_core
// 2x2 mean or upper pass-through with null handling for one column pair
// ----------------------------------------------------------------------------
module trba_avg_core (
    input  trba_pkg::work_t   work,
    input  trba_pkg::cfg_t    cfg,
    output logic              emit,
    output trba_pkg::result_t result
);
    import trba_pkg::*;

    logic signed [SUM_W-1:0]  t1;
    logic signed [SUM_W-1:0]  t2;
    logic signed [SUM_W-1:0]  t3;
    logic signed [SUM_W-1:0]  t4;
    logic signed [SUM_W-1:0]  sum;
    logic signed [SUM_W-1:0]  quarter;
    logic                     any_null;
    logic                     is_null;
    logic signed [ELEV_W-1:0] val;

    assign emit = work.valid && !work.row_start && work.have_prev;

    // null samples count as zero in the sum
    assign t1 = work.prev_upper_null ? '0 : SUM_W'(work.prev_upper);
    assign t2 = work.prev_lower_null ? '0 : SUM_W'(work.prev_lower);
    assign t3 = work.upper_null      ? '0 : SUM_W'(work.upper_elev);
    assign t4 = work.lower_null      ? '0 : SUM_W'(work.lower_elev);

    assign sum     = t1 + t2 + t3 + t4;
    assign quarter = sum >>> 2;

    assign any_null = work.prev_upper_null || work.prev_lower_null
                   || work.upper_null || work.lower_null;

    always_comb
    begin
        if (cfg.average_enable)
        begin
            is_null = any_null && !cfg.null_as_zero;
            val     = quarter[ELEV_W-1:0];
        end
        else
        begin
            is_null = work.prev_upper_null && !cfg.null_as_zero;
            val     = work.prev_upper_null ? '0 : work.prev_upper;
        end
    end

    assign result.out_elev = is_null ? '0 : val;
    assign result.out_null = is_null;
    assign result.out_last = work.row_end;

endmodule

// ===== src/trba_out_reg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trba_out_reg
// result register driving the output channel
// ----------------------------------------------------------------------------
module trba_out_reg (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  trba_pkg::result_t result,
    output logic              can_take,
    trba_results_if.source    results
);
    import trba_pkg::*;

    logic    valid_reg;
    result_t data_reg;

    assign can_take = !valid_reg || results.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (can_take)
        begin
            valid_reg <= load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && can_take)
        begin
            data_reg <= result;
        end
    end

    assign results.valid    = valid_reg;
    assign results.out_elev = data_reg.out_elev;
    assign results.out_null = data_reg.out_null;
    assign results.out_last = data_reg.out_last;

endmodule

// ===== bench/two_row_box_average_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_row_box_average_test
// self-checking bench for the two-row 2x2 box filter
// ----------------------------------------------------------------------------
// Feeds raster columns through the sample channel with random idle bursts on
// both sides. A local filter model predicts every result at the moment its
// column is accepted, and each result taken from the block is checked field
// by field against the oldest prediction. Runs directed corner columns first,
// then random rows under every mode setting.
// ----------------------------------------------------------------------------
module two_row_box_average_test;
    import trba_pkg::*;

    typedef struct packed {
        logic signed [ELEV_W-1:0] upper_elev;
        logic signed [ELEV_W-1:0] lower_elev;
        logic                     upper_null;
        logic                     lower_null;
        logic                     row_start;
        logic                     row_end;
    } column_t;

    localparam logic signed [ELEV_W-1:0] ELEV_MAX = 32'sh7fffffff;
    localparam logic signed [ELEV_W-1:0] ELEV_MIN = 32'sh80000000;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 wr_en;
    logic [CFG_IDX_W-1:0] wr_idx;
    logic [CFG_DAT_W-1:0] wr_data;

    trba_samples_if samples_ch ();
    trba_results_if results_ch ();

    two_row_box_average uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (wr_en),
        .wr_idx  (wr_idx),
        .wr_data (wr_data),
        .samples (samples_ch),
        .results (results_ch)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // filter model: mode copy and the held column
    logic                     avg_on;
    logic                     zero_nulls;
    logic signed [ELEV_W-1:0] held_upper;
    logic signed [ELEV_W-1:0] held_lower;
    logic                     held_upper_null;
    logic                     held_lower_null;
    logic                     column_held;

    column_t column_queue[$];
    result_t expected_cells[$];
    column_t cur_col;
    bit      col_accepted;
    bit      calm;
    int      idle_odds;
    int      src_gap;
    int      sink_gap;
    int      error_count;

    task automatic report_mismatch(input string msg);
        begin
            $display("[%0t] mismatch: %s", $time, msg);
            error_count++;
        end
    endtask

    task automatic filter_column(input column_t col);
        logic signed [ELEV_W-1:0] a;
        logic signed [ELEV_W-1:0] b;
        logic signed [ELEV_W-1:0] c;
        logic signed [ELEV_W-1:0] d;
        logic signed [SUM_W-1:0]  total;
        result_t                  pred;
        begin
            if (!col.row_start && column_held)
            begin
                pred.out_last = col.row_end;
                pred.out_null = 1'b0;
                pred.out_elev = '0;
                if (avg_on)
                begin
                    a = held_upper_null ? '0 : held_upper;
                    b = held_lower_null ? '0 : held_lower;
                    c = col.upper_null ? '0 : col.upper_elev;
                    d = col.lower_null ? '0 : col.lower_elev;
                    total = a + b + c + d;
                    if (!zero_nulls && (held_upper_null || held_lower_null
                                        || col.upper_null || col.lower_null))
                        pred.out_null = 1'b1;
                    else
                        pred.out_elev = ELEV_W'(total >>> 2);  // floor of quarter
                end
                else if (held_upper_null)
                    pred.out_null = !zero_nulls;
                else
                    pred.out_elev = held_upper;
                expected_cells.push_back(pred);
            end
            held_upper      = col.upper_elev;
            held_lower      = col.lower_elev;
            held_upper_null = col.upper_null;
            held_lower_null = col.lower_null;
            column_held     = !col.row_end;
        end
    endtask

    // column driver
    always @(negedge clk)
    begin
        if (rst_n && (!samples_ch.valid || col_accepted))
        begin
            col_accepted = 1'b0;
            if (src_gap != 0)
            begin
                src_gap--;
                samples_ch.valid <= 1'b0;
            end
            else if (!calm && $urandom_range(0, idle_odds - 1) == 0)
            begin
                src_gap = $urandom_range(0, 15);
                samples_ch.valid <= 1'b0;
            end
            else if (column_queue.size() != 0)
            begin
                cur_col = column_queue.pop_front();
                samples_ch.valid      <= 1'b1;
                samples_ch.upper_elev <= cur_col.upper_elev;
                samples_ch.lower_elev <= cur_col.lower_elev;
                samples_ch.upper_null <= cur_col.upper_null;
                samples_ch.lower_null <= cur_col.lower_null;
                samples_ch.row_start  <= cur_col.row_start;
                samples_ch.row_end    <= cur_col.row_end;
            end
            else
                samples_ch.valid <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && samples_ch.valid && samples_ch.ready)
        begin
            filter_column(cur_col);
            col_accepted = 1'b1;
        end
    end

    // result side: ready stalls and checking
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (sink_gap != 0)
            begin
                sink_gap--;
                results_ch.ready <= 1'b0;
            end
            else if (!calm && $urandom_range(0, idle_odds - 1) == 0)
            begin
                sink_gap = $urandom_range(0, 15);
                results_ch.ready <= 1'b0;
            end
            else
                results_ch.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && results_ch.valid && results_ch.ready)
        begin
            if (expected_cells.size() == 0)
                report_mismatch($sformatf("unexpected result elev=%0d null=%0b last=%0b",
                    results_ch.out_elev, results_ch.out_null, results_ch.out_last));
            else
            begin
                automatic result_t want = expected_cells.pop_front();
                if (results_ch.out_elev !== want.out_elev)
                    report_mismatch($sformatf("out_elev got %0d want %0d",
                        results_ch.out_elev, want.out_elev));
                if (results_ch.out_null !== want.out_null)
                    report_mismatch($sformatf("out_null got %0b want %0b",
                        results_ch.out_null, want.out_null));
                if (results_ch.out_last !== want.out_last)
                    report_mismatch($sformatf("out_last got %0b want %0b",
                        results_ch.out_last, want.out_last));
            end
        end
    end

    task automatic push_column(input logic signed [ELEV_W-1:0] up, input logic signed [ELEV_W-1:0] lo,
                               input logic un, input logic ln, input logic rs, input logic re);
        column_t col;
        begin
            col.upper_elev = up;
            col.lower_elev = lo;
            col.upper_null = un;
            col.lower_null = ln;
            col.row_start  = rs;
            col.row_end    = re;
            column_queue.push_back(col);
        end
    endtask

    // wait until every column is in and every result is out
    task automatic drain;
        begin
            while (column_queue.size() != 0 || samples_ch.valid)
                @(posedge clk);
            while (expected_cells.size() != 0)
                @(posedge clk);
            // a row start column may still be in the pipe
            repeat (4) @(posedge clk);
        end
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic val);
        begin
            @(negedge clk);
            wr_en   <= 1'b1;
            wr_idx  <= idx;
            wr_data <= val;
            @(posedge clk);
            case (idx)
                CFG_AVERAGE_ENABLE: avg_on = val;
                CFG_NULL_AS_ZERO:   zero_nulls = val;
                default: ;
            endcase
            @(negedge clk);
            wr_en <= 1'b0;
        end
    endtask

    function automatic logic signed [ELEV_W-1:0] rand_elev;
        case ($urandom_range(0, 7))
            0:       return ELEV_MAX;
            1:       return ELEV_MIN;
            2, 3:    return $urandom_range(0, 2000) - 1000;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic rand_null;
        return $urandom_range(0, 7) == 0;
    endfunction

    task automatic push_random_rows(input int n_items);
        int count;
        int len;
        begin
            count = 0;
            while (count < n_items)
            begin
                if ($urandom_range(0, 9) < 8)
                begin
                    len = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 60)
                                                       : $urandom_range(1, 8);
                    push_column(rand_elev(), rand_elev(), rand_null(), rand_null(), 1'b1, 1'b0);
                    for (int i = 1; i <= len; i++)
                        push_column(rand_elev(), rand_elev(), rand_null(), rand_null(),
                                    1'b0, i == len);
                    count += len + 1;
                end
                else
                begin
                    // broken rows: markers anywhere
                    len = $urandom_range(1, 6);
                    for (int i = 0; i < len; i++)
                        push_column(rand_elev(), rand_elev(), rand_null(), rand_null(),
                                    $urandom_range(0, 3) == 0, $urandom_range(0, 3) == 0);
                    count += len;
                end
            end
        end
    endtask

    initial
    begin
        rst_n                 = 1'b0;
        wr_en                 = 1'b0;
        wr_idx                = CFG_AVERAGE_ENABLE;
        wr_data               = '0;
        samples_ch.valid      = 1'b0;
        samples_ch.upper_elev = '0;
        samples_ch.lower_elev = '0;
        samples_ch.upper_null = 1'b0;
        samples_ch.lower_null = 1'b0;
        samples_ch.row_start  = 1'b0;
        samples_ch.row_end    = 1'b0;
        results_ch.ready      = 1'b0;
        avg_on                = 1'b1;
        zero_nulls            = 1'b0;
        held_upper            = '0;
        held_lower            = '0;
        held_upper_null       = 1'b0;
        held_lower_null       = 1'b0;
        column_held           = 1'b0;
        col_accepted          = 1'b0;
        calm                  = 1'b0;
        idle_odds             = 16;
        src_gap               = 0;
        sink_gap              = 0;
        error_count           = 0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // averaging, nulls propagate
        push_column(ELEV_MAX, ELEV_MAX, 1'b0, 1'b0, 1'b0, 1'b0);  // no held column yet
        push_column(ELEV_MAX, ELEV_MAX, 1'b0, 1'b0, 1'b0, 1'b0);
        push_column(ELEV_MIN, ELEV_MIN, 1'b0, 1'b0, 1'b0, 1'b0);
        push_column(ELEV_MIN, ELEV_MIN, 1'b0, 1'b0, 1'b0, 1'b0);
        push_column(-1, 0, 1'b0, 1'b0, 1'b0, 1'b0);
        push_column(5, 7, 1'b0, 1'b0, 1'b1, 1'b0);                // start over a held column
        push_column(1, 2, 1'b0, 1'b0, 1'b0, 1'b0);
        push_column(11, 12, 1'b1, 1'b0, 1'b0, 1'b0);
        push_column(13, 14, 1'b0, 1'b1, 1'b0, 1'b0);
        push_column(3, 3, 1'b0, 1'b0, 1'b0, 1'b0);
        push_column(-3, -2, 1'b0, 1'b0, 1'b0, 1'b0);
        push_column(10, 10, 1'b0, 1'b0, 1'b0, 1'b1);
        push_column(4, 4, 1'b0, 1'b0, 1'b1, 1'b1);                // start and end together
        push_column(8, 8, 1'b0, 1'b0, 1'b0, 1'b0);
        push_column(0, 0, 1'b0, 1'b0, 1'b0, 1'b1);
        drain();
        write_reg(CFG_NULL_AS_ZERO, 1'b1);
        push_column(ELEV_MIN, ELEV_MAX, 1'b1, 1'b0, 1'b1, 1'b0);
        push_column(ELEV_MAX, ELEV_MIN, 1'b0, 1'b1, 1'b0, 1'b0);
        drain();
        write_reg(CFG_AVERAGE_ENABLE, 1'b0);
        push_column(7, 6, 1'b0, 1'b1, 1'b1, 1'b0);
        push_column(-5, 1, 1'b0, 1'b0, 1'b0, 1'b0);
        push_column(100, 2, 1'b1, 1'b0, 1'b0, 1'b0);
        push_column(9, 3, 1'b0, 1'b0, 1'b0, 1'b0);
        drain();
        write_reg(CFG_NULL_AS_ZERO, 1'b0);
        push_column(1, 4, 1'b1, 1'b0, 1'b0, 1'b0);
        push_column(2, 5, 1'b0, 1'b0, 1'b0, 1'b1);
        drain();

        // random rows under every mode pair, the last phase without stalls
        for (int phase = 0; phase < 8; phase++)
        begin
            write_reg(CFG_AVERAGE_ENABLE, (phase % 2) == 0);
            write_reg(CFG_NULL_AS_ZERO, ((phase / 2) % 2) == 1);
            idle_odds = 1 << $urandom_range(2, 6);
            calm      = (phase == 7);
            push_random_rows(205);
            drain();
        end

        repeat (8) @(posedge clk);
        if (error_count == 0)
            $display("two_row_box_average_test OK");
        else
            $display("two_row_box_average_test NOT OK");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("two_row_box_average_test NOT OK");
        $finish;
    end

endmodule
